/* src/srsp_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srsp_pkg: shared types and constants
// Operation, phase and drive codes, register indexes and the work struct.
// ----------------------------------------------------------------------------
package srsp_pkg;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_START = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_RUN   = 3'd1,
    PH_BRAKE = 3'd2,
    PH_DONE  = 3'd3,
    PH_FAULT = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    DRV_NONE  = 2'd0,
    DRV_FWD   = 2'd1,
    DRV_STOP  = 2'd2,
    DRV_ESTOP = 2'd3
  } drive_t;

  localparam logic [2:0] REG_TARGET      = 3'd0;
  localparam logic [2:0] REG_WINDOW      = 3'd1;
  localparam logic [2:0] REG_CRUISE      = 3'd2;
  localparam logic [2:0] REG_END         = 3'd3;
  localparam logic [2:0] REG_ACCEL_TICKS = 3'd4;
  localparam logic [2:0] REG_DECEL_TICKS = 3'd5;
  localparam logic [2:0] REG_BRAKE_MIN   = 3'd6;
  localparam logic [2:0] REG_BRAKE_TMO   = 3'd7;

  // Classified item handed from the front to the back.
  typedef struct packed {
    op_t         op;
    logic [33:0] sum;      // total absolute counts of the wheels
    logic        stopped;  // all wheels inside the deadband
  } work_t;

endpackage

`default_nettype wire

/* src/srsp_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srsp_front: input stage
// Accept items, sum wheel magnitudes, check the deadband, queue the work.
// ----------------------------------------------------------------------------
module srsp_front #(
  parameter int STOP_DEADBAND = 2,
  parameter int WHEEL_COUNT   = 4
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  output logic                 full,
  input  wire  [1:0]           operation,
  input  wire  signed [15:0]   wheel_speed_a,
  input  wire  signed [15:0]   wheel_speed_b,
  input  wire  signed [15:0]   wheel_speed_c,
  input  wire  signed [15:0]   wheel_speed_d,
  output logic                 work_valid,
  output srsp_pkg::work_t      work,
  input  wire                  work_take
);
  import srsp_pkg::*;

  localparam int USED = (WHEEL_COUNT < 4) ? WHEEL_COUNT : 4;

  logic signed [15:0] w [4];
  logic [16:0]        mg [4];
  logic [33:0]        sum_c;
  logic               stop_c;
  work_t              q [2];
  logic               wr_ptr, rd_ptr;
  logic [1:0]         fill;
  logic               do_push, do_pop;

  assign w[0] = wheel_speed_a;
  assign w[1] = wheel_speed_b;
  assign w[2] = wheel_speed_c;
  assign w[3] = wheel_speed_d;

  always_comb begin
    sum_c  = '0;
    stop_c = 1'b1;
    for (int i = 0; i < 4; i++) begin
      mg[i] = w[i][15] ? (17'd0 - {w[i][15], w[i]}) : {1'b0, w[i]};
      if (i < USED) begin
        sum_c = sum_c + {17'd0, mg[i]};
        if (mg[i] > 17'(STOP_DEADBAND)) stop_c = 1'b0;
      end
    end
  end

  assign full       = fill[1];
  assign work_valid = (fill != 2'd0);
  assign work       = q[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = work_take && work_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= '{op: op_t'(operation), sum: sum_c, stopped: stop_c};
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd2 |=> fill != 2'd0 || $past(do_pop)) else $error("queue fill");
  a_fill_max: assert property (@(posedge clk) disable iff (rst)
    fill != 2'd3) else $error("queue fill above depth");
  a_empty_no_valid: assert property (@(posedge clk) disable iff (rst)
    fill == 2'd0 |-> !work_valid) else $error("valid while empty");
`endif

endmodule

`default_nettype wire

/* src/srsp_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srsp_divider: restoring divider
// Unsigned 32 by 16 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srsp_divider (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  input  wire  [31:0] dividend,
  input  wire  [15:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);
  logic [31:0] quo;
  logic [16:0] rem;
  logic [15:0] dvs;
  logic [5:0]  cnt;
  logic [17:0] trial;

  assign trial    = {rem, quo[31]} - {2'b00, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[17]) begin
        rem <= trial[16:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= {rem[15:0], quo[31]};
        quo <= {quo[30:0], 1'b0};
      end
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without busy");
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    busy |-> !start) else $error("start while busy");
  a_count_live: assert property (@(posedge clk) disable iff (rst)
    busy |-> cnt != 6'd0) else $error("busy with zero count");
`endif

endmodule

`default_nettype wire

/* src/srsp_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// srsp_back: profile sequencer
// Carry out each item against the run state and register the result.
// ----------------------------------------------------------------------------
module srsp_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  work_valid,
  input  srsp_pkg::work_t      work,
  output logic                 work_take,
  input  wire  [31:0]          target_counts,
  input  wire  [31:0]          decel_window_counts,
  input  wire  [14:0]          cruise_rpm,
  input  wire  [14:0]          decel_end_rpm,
  input  wire  [15:0]          accel_ramp_ticks,
  input  wire  [15:0]          decel_ramp_ticks,
  input  wire  [15:0]          brake_min_ticks,
  input  wire  [15:0]          brake_timeout_ticks,
  output logic                 empty,
  input  wire                  pop,
  output logic [2:0]           phase,
  output logic [1:0]           drive_command,
  output logic [14:0]          speed_command,
  output logic                 start_accepted
);
  import srsp_pkg::*;

  typedef enum logic [1:0] {
    SQ_WAIT = 2'd0,
    SQ_MUL  = 2'd1,
    SQ_DIV  = 2'd2,
    SQ_OUT  = 2'd3
  } seq_t;

  seq_t        sq, sq_next;
  phase_t      run_phase;
  logic [31:0] travelled;
  logic [15:0] accel_cnt, decel_cnt, brake_cnt;
  logic [14:0] last_speed, decel_start;
  logic        decel_begun;
  logic        out_full;

  // division job
  logic        dec_job;     // decel ramp vs accel ramp
  logic        neg;         // decel: start below end
  logic [15:0] mul_a;
  logic [15:0] mul_b;
  logic [31:0] product;
  logic [15:0] div_den;
  logic        div_start, div_busy, div_done;
  logic [31:0] div_q;

  // combinational evaluation of the item
  logic [33:0] tot;
  logic [31:0] trav_n, remaining;
  logic        in_window, need_div;
  logic [15:0] accel_n, decel_n, brake_n;
  logic [14:0] dstart_n, direct_speed;
  logic        can_take;
  logic [15:0] step;
  logic [14:0] div_speed;

  srsp_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(product),
    .divisor(div_den), .busy(div_busy), .done(div_done), .quotient(div_q)
  );

  assign can_take  = (sq == SQ_WAIT) && work_valid && !out_full;
  assign work_take = can_take;
  assign empty     = !out_full;

  always_comb begin
    tot       = {2'b00, travelled} + work.sum;
    trav_n    = tot[33:32] != 2'b00 ? 32'hFFFF_FFFF : tot[31:0];
    remaining = target_counts - trav_n;
    in_window = (decel_window_counts != 32'd0) && (remaining <= decel_window_counts);
    dstart_n  = decel_begun ? decel_start
              : (last_speed < decel_end_rpm ? decel_end_rpm : last_speed);
    decel_n   = decel_begun ? decel_cnt : 16'd0;
    if (decel_n < decel_ramp_ticks) decel_n = decel_n + 16'd1;
    accel_n   = accel_cnt;
    if (accel_n < accel_ramp_ticks) accel_n = accel_n + 16'd1;
    brake_n   = brake_cnt == 16'hFFFF ? brake_cnt : brake_cnt + 16'd1;
    need_div  = in_window ? (decel_ramp_ticks != 16'd0) : (accel_ramp_ticks != 16'd0);
    direct_speed = in_window ? decel_end_rpm : cruise_rpm;
  end

  // 16 by 16 product of the registered operands, ready when the divider starts
  assign product = {16'd0, mul_a} * {16'd0, mul_b};

  // truncated quotient; signed for the decel ramp
  assign step      = div_q[15:0];
  assign div_speed = !dec_job ? div_q[14:0]
                   : (neg ? decel_start + step[14:0] : decel_start - step[14:0]);

  always_comb begin
    sq_next = sq;
    case (sq)
      SQ_WAIT: if (can_take && work.op == OP_TICK && run_phase == PH_RUN &&
                   trav_n < target_counts && need_div) sq_next = SQ_MUL;
      SQ_MUL:  sq_next = SQ_DIV;
      SQ_DIV:  if (div_done) sq_next = SQ_OUT;
      SQ_OUT:  sq_next = SQ_WAIT;
      default: sq_next = SQ_WAIT;
    endcase
  end

  assign div_start = (sq == SQ_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      sq             <= SQ_WAIT;
      run_phase      <= PH_IDLE;
      travelled      <= '0;
      accel_cnt      <= '0;
      decel_cnt      <= '0;
      brake_cnt      <= '0;
      last_speed     <= '0;
      decel_start    <= '0;
      decel_begun    <= 1'b0;
      out_full       <= 1'b0;
      phase          <= PH_IDLE;
      drive_command  <= DRV_NONE;
      speed_command  <= '0;
      start_accepted <= 1'b0;
      dec_job        <= 1'b0;
      neg            <= 1'b0;
      mul_a          <= '0;
      mul_b          <= '0;
      div_den        <= 16'd1;
    end else begin
      sq <= sq_next;
      if (sq == SQ_OUT) begin
        speed_command <= div_speed;
        last_speed    <= div_speed;
      end
      if (pop && out_full) out_full <= 1'b0;
      if (sq == SQ_OUT) out_full <= 1'b1;
      if (can_take) begin
        drive_command  <= DRV_NONE;
        speed_command  <= '0;
        start_accepted <= 1'b0;
        out_full       <= !(work.op == OP_TICK && run_phase == PH_RUN &&
                            trav_n < target_counts && need_div);
        case (work.op)
          OP_START: begin
            if (target_counts != 0 && cruise_rpm != 0 && decel_end_rpm != 0 &&
                decel_end_rpm <= cruise_rpm && decel_window_counts <= target_counts) begin
              run_phase <= PH_RUN;
              travelled <= '0; accel_cnt <= '0; decel_cnt <= '0; brake_cnt <= '0;
              last_speed <= '0; decel_start <= '0; decel_begun <= 1'b0;
              drive_command  <= DRV_STOP;
              start_accepted <= 1'b1;
              phase <= PH_RUN;
            end else begin
              phase <= run_phase;
            end
          end
          OP_CLEAR: begin
            run_phase <= PH_IDLE;
            travelled <= '0; accel_cnt <= '0; decel_cnt <= '0; brake_cnt <= '0;
            last_speed <= '0; decel_start <= '0; decel_begun <= 1'b0;
            drive_command <= DRV_STOP;
            phase <= PH_IDLE;
          end
          OP_TICK: begin
            phase <= run_phase;
            if (run_phase == PH_RUN) begin
              travelled <= trav_n;
              if (trav_n >= target_counts) begin
                brake_cnt     <= '0;
                run_phase     <= PH_BRAKE;
                phase         <= PH_BRAKE;
                drive_command <= DRV_STOP;
              end else begin
                drive_command <= DRV_FWD;
                if (in_window) begin
                  decel_begun <= 1'b1;
                  decel_start <= dstart_n;
                  decel_cnt   <= decel_n;
                end else begin
                  accel_cnt <= accel_n;
                end
                if (!need_div) begin
                  speed_command <= direct_speed;
                  last_speed    <= direct_speed;
                end
                dec_job <= in_window;
                neg     <= dstart_n < decel_end_rpm;
                mul_a   <= in_window ? {1'b0, (dstart_n < decel_end_rpm ?
                             decel_end_rpm - dstart_n : dstart_n - decel_end_rpm)}
                           : {1'b0, cruise_rpm};
                mul_b   <= in_window ? decel_n : accel_n;
                div_den <= in_window ? decel_ramp_ticks : accel_ramp_ticks;
              end
            end else if (run_phase == PH_BRAKE) begin
              brake_cnt <= brake_n;
              if (brake_n >= brake_min_ticks && work.stopped) begin
                run_phase <= PH_DONE;
                phase     <= PH_DONE;
              end else if (brake_n >= brake_timeout_ticks) begin
                run_phase     <= PH_FAULT;
                phase         <= PH_FAULT;
                drive_command <= DRV_ESTOP;
              end
            end
          end
          default: phase <= run_phase;
        endcase
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_take_only_waiting: assert property (@(posedge clk) disable iff (rst)
    work_take |-> sq == SQ_WAIT && !out_full) else $error("take while busy");
  a_fwd_has_run: assert property (@(posedge clk) disable iff (rst)
    out_full && drive_command == DRV_FWD |-> phase == PH_RUN) else $error("fwd not run");
  a_speed_zero: assert property (@(posedge clk) disable iff (rst)
    out_full && drive_command != DRV_FWD |-> speed_command == 15'd0)
    else $error("speed without fwd");
  a_div_ends: assert property (@(posedge clk) disable iff (rst)
    sq == SQ_DIV && !div_busy && !div_done |-> 1'b0) else $error("divider lost");
`endif

endmodule

`default_nettype wire

/* src/straight_run_speed_profiler.sv */
`default_nettype none
// Straight-run speed profiler. Items enter through a push/full queue port and
// each gives one result read through empty/pop. A tick that lands on a ramp
// holds the back end while the 32-step restoring divider scales the ramp,
// through the take, multiply, divide (until the divider's done) and result
// states; every other item is finished in its take cycle. A two-entry queue
// sits between the input stage, which sums wheel magnitudes and checks the
// stop deadband, and the sequencer, so input can be taken while a result
// waits. Registers are written on cfg_valid/cfg_ready (always ready) and
// apply at once.
// ----------------------------------------------------------------------------
// straight_run_speed_profiler: top level
// Register file, input stage and profile sequencer.
// ----------------------------------------------------------------------------
module straight_run_speed_profiler #(
  parameter int STOP_DEADBAND = 2,
  parameter int WHEEL_COUNT   = 4
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  output logic               full,
  input  wire  [1:0]         operation,
  input  wire  signed [15:0] wheel_speed_a,
  input  wire  signed [15:0] wheel_speed_b,
  input  wire  signed [15:0] wheel_speed_c,
  input  wire  signed [15:0] wheel_speed_d,
  output logic               empty,
  input  wire                pop,
  output logic [2:0]         phase,
  output logic [1:0]         drive_command,
  output logic [14:0]        speed_command,
  output logic               start_accepted,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [2:0]         cfg_index,
  input  wire  [31:0]        cfg_data
);
  import srsp_pkg::*;

  logic [31:0] target_counts, decel_window_counts;
  logic [14:0] cruise_rpm, decel_end_rpm;
  logic [15:0] accel_ramp_ticks, decel_ramp_ticks, brake_min_ticks, brake_timeout_ticks;
  logic        work_valid, work_take;
  work_t       work;

  assign cfg_ready = 1'b1;

  // register file; every index is defined
  always_ff @(posedge clk) begin
    if (rst) begin
      target_counts <= '0; decel_window_counts <= '0;
      cruise_rpm <= '0; decel_end_rpm <= '0;
      accel_ramp_ticks <= '0; decel_ramp_ticks <= '0;
      brake_min_ticks <= '0; brake_timeout_ticks <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET:      target_counts       <= cfg_data;
        REG_WINDOW:      decel_window_counts <= cfg_data;
        REG_CRUISE:      cruise_rpm          <= cfg_data[14:0];
        REG_END:         decel_end_rpm       <= cfg_data[14:0];
        REG_ACCEL_TICKS: accel_ramp_ticks    <= cfg_data[15:0];
        REG_DECEL_TICKS: decel_ramp_ticks    <= cfg_data[15:0];
        REG_BRAKE_MIN:   brake_min_ticks     <= cfg_data[15:0];
        REG_BRAKE_TMO:   brake_timeout_ticks <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  srsp_front #(.STOP_DEADBAND(STOP_DEADBAND), .WHEEL_COUNT(WHEEL_COUNT)) u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .operation(operation),
    .wheel_speed_a(wheel_speed_a), .wheel_speed_b(wheel_speed_b),
    .wheel_speed_c(wheel_speed_c), .wheel_speed_d(wheel_speed_d),
    .work_valid(work_valid), .work(work), .work_take(work_take)
  );

  srsp_back u_back (
    .clk(clk), .rst(rst), .work_valid(work_valid), .work(work), .work_take(work_take),
    .target_counts(target_counts), .decel_window_counts(decel_window_counts),
    .cruise_rpm(cruise_rpm), .decel_end_rpm(decel_end_rpm),
    .accel_ramp_ticks(accel_ramp_ticks), .decel_ramp_ticks(decel_ramp_ticks),
    .brake_min_ticks(brake_min_ticks), .brake_timeout_ticks(brake_timeout_ticks),
    .empty(empty), .pop(pop), .phase(phase), .drive_command(drive_command),
    .speed_command(speed_command), .start_accepted(start_accepted)
  );

endmodule

`default_nettype wire
